[rtl/tpe_pkg.sv]
// Shared constants, types and the reciprocal table of the threshold pulse extractor.
package tpe_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int AREA_BITS   = 32;
  localparam int WINDOW_LEN  = 7;

  localparam int FILL_W      = $clog2(WINDOW_LEN + 1);
  localparam int TOTAL_W     = SAMPLE_BITS + FILL_W;
  localparam int RECIP_SHIFT = TOTAL_W + FILL_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = TOTAL_W + RECIP_W;

  localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MULT,
    ST_EMIT
  } tpe_state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic mult;
    logic emit;
  } tpe_cmd_t;

  typedef struct packed {
    logic has_result;
  } tpe_status_t;

  // Rounded-up reciprocal of the window fill, scaled by two to the RECIP_SHIFT.
  function automatic logic [RECIP_W-1:0] recip(input logic [FILL_W-1:0] n);
    logic [RECIP_W-1:0] r;
    r = '0;
    case (int'(n))
      1:       r = RECIP_W'(RECIP_ONE);
      2:       r = RECIP_W'((RECIP_ONE + 64'd1) / 64'd2);
      3:       r = RECIP_W'((RECIP_ONE + 64'd2) / 64'd3);
      4:       r = RECIP_W'((RECIP_ONE + 64'd3) / 64'd4);
      5:       r = RECIP_W'((RECIP_ONE + 64'd4) / 64'd5);
      6:       r = RECIP_W'((RECIP_ONE + 64'd5) / 64'd6);
      7:       r = RECIP_W'((RECIP_ONE + 64'd6) / 64'd7);
      8:       r = RECIP_W'((RECIP_ONE + 64'd7) / 64'd8);
      9:       r = RECIP_W'((RECIP_ONE + 64'd8) / 64'd9);
      10:      r = RECIP_W'((RECIP_ONE + 64'd9) / 64'd10);
      11:      r = RECIP_W'((RECIP_ONE + 64'd10) / 64'd11);
      12:      r = RECIP_W'((RECIP_ONE + 64'd11) / 64'd12);
      13:      r = RECIP_W'((RECIP_ONE + 64'd12) / 64'd13);
      14:      r = RECIP_W'((RECIP_ONE + 64'd13) / 64'd14);
      15:      r = RECIP_W'((RECIP_ONE + 64'd14) / 64'd15);
      16:      r = RECIP_W'((RECIP_ONE + 64'd15) / 64'd16);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/tpe_ctrl.sv]
// Sequencing state machine and output valid flag of the threshold pulse extractor.
module tpe_ctrl
  import tpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  tpe_status_t status_i,
  output tpe_cmd_t    cmd_o
);

  tpe_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.has_result ? ST_MULT : ST_IDLE;
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/tpe_datapath.sv]
// Pulse state, moving-average window, divider by reciprocal and result register.
module tpe_datapath
  import tpe_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tpe_cmd_t                      cmd_i,
  output tpe_status_t                   status_o,
  input  logic                          cfg_we_i,
  input  logic signed [SAMPLE_BITS-1:0] cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          capture_end_i,
  output logic signed [SAMPLE_BITS-1:0] raw_value_o,
  output logic signed [SAMPLE_BITS-1:0] smoothed_value_o,
  output logic                          pulse_done_o,
  output logic                          pulse_abandoned_o,
  output logic signed [SAMPLE_BITS-1:0] pulse_peak_o,
  output logic signed [AREA_BITS-1:0]   pulse_area_o
);

  localparam logic signed [AREA_BITS:0] AREA_MAX = (AREA_BITS + 1)'({1'b0, {(AREA_BITS-1){1'b1}}});
  localparam logic signed [AREA_BITS:0] AREA_MIN = -AREA_MAX - (AREA_BITS + 1)'(1);

  logic signed [SAMPLE_BITS-1:0] bg_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          cap_end_q;
  logic                          in_pulse_q;
  logic signed [SAMPLE_BITS-1:0] win_q [WINDOW_LEN];
  logic [FILL_W-1:0]             fill_q;
  logic signed [TOTAL_W-1:0]     total_q;
  logic [TOTAL_W-1:0]            mag_q;
  logic                          neg_q;
  logic signed [SAMPLE_BITS-1:0] peak_q;
  logic signed [AREA_BITS-1:0]   area_q;
  logic                          done_q;
  logic                          abandon_q;
  logic [PROD_W-1:0]             prod_q;

  logic                          opening;
  logic                          has_result;
  logic [FILL_W-1:0]             fill_cur, fill_d;
  logic signed [TOTAL_W-1:0]     total_cur, total_d;
  logic signed [SAMPLE_BITS-1:0] peak_cur, peak_d;
  logic signed [AREA_BITS-1:0]   area_cur, area_d;
  logic signed [AREA_BITS:0]     area_sum;
  logic                          full;
  logic                          done_d;
  logic                          abandon_d;
  logic [TOTAL_W-1:0]            quot;
  logic [TOTAL_W-1:0]            smooth_full;

  assign opening    = !in_pulse_q && (sample_q > bg_q);
  assign has_result = in_pulse_q || opening;
  assign status_o.has_result = has_result;

  always_comb begin
    fill_cur  = opening ? '0 : fill_q;
    total_cur = opening ? '0 : total_q;
    area_cur  = opening ? '0 : area_q;
    peak_cur  = opening ? sample_q : peak_q;
    full      = (fill_cur == FILL_W'(WINDOW_LEN));
    fill_d    = full ? fill_cur : fill_cur + FILL_W'(1);
    total_d   = total_cur + TOTAL_W'(sample_q)
              - (full ? TOTAL_W'(win_q[WINDOW_LEN-1]) : '0);
    peak_d    = (sample_q > peak_cur) ? sample_q : peak_cur;
    area_sum  = (AREA_BITS + 1)'(area_cur) + (AREA_BITS + 1)'(sample_q);
    if (area_sum > AREA_MAX) begin
      area_d = AREA_BITS'(AREA_MAX);
    end else if (area_sum < AREA_MIN) begin
      area_d = AREA_BITS'(AREA_MIN);
    end else begin
      area_d = AREA_BITS'(area_sum);
    end
    done_d    = (sample_q < bg_q);
    abandon_d = !done_d && cap_end_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q       <= '0;
      in_pulse_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bg_q <= cfg_wdata_i;
      end
      if (cmd_i.update && has_result) begin
        in_pulse_q <= !(done_d || abandon_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q  <= sample_i;
      cap_end_q <= capture_end_i;
    end
    if (cmd_i.update && has_result) begin
      win_q[0] <= sample_q;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_q[i] <= win_q[i-1];
      end
      fill_q    <= fill_d;
      total_q   <= total_d;
      neg_q     <= total_d[TOTAL_W-1];
      mag_q     <= total_d[TOTAL_W-1] ? TOTAL_W'(-total_d) : TOTAL_W'(total_d);
      peak_q    <= peak_d;
      area_q    <= area_d;
      done_q    <= done_d;
      abandon_q <= abandon_d;
    end
    if (cmd_i.mult) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(recip(fill_q));
    end
    if (cmd_i.emit) begin
      raw_value_o       <= sample_q;
      smoothed_value_o  <= SAMPLE_BITS'(smooth_full);
      pulse_done_o      <= done_q;
      pulse_abandoned_o <= abandon_q;
      pulse_peak_o      <= done_q ? peak_q : '0;
      pulse_area_o      <= done_q ? area_q : '0;
    end
  end

  assign quot        = prod_q[RECIP_SHIFT +: TOTAL_W];
  assign smooth_full = neg_q ? TOTAL_W'(-quot) : quot;

endmodule

[rtl/threshold_pulse_extractor_unit.sv]
// Top level of the threshold pulse extractor: controller plus datapath.
// After the accepting edge a result passes the window update, the reciprocal multiply and
// the result register before it is valid; a stalled earlier result holds it in the last step.
// The input stays stalled until the controller sequence is back in idle, so a new request is
// taken only once the last one is through; a sample outside any pulse gives no result.
// Reset clears the threshold, pulse state and valid flag; window data needs none.
module threshold_pulse_extractor_unit
  import tpe_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic signed [SAMPLE_BITS-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          capture_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] raw_value_o,
  output logic signed [SAMPLE_BITS-1:0] smoothed_value_o,
  output logic                          pulse_done_o,
  output logic                          pulse_abandoned_o,
  output logic signed [SAMPLE_BITS-1:0] pulse_peak_o,
  output logic signed [AREA_BITS-1:0]   pulse_area_o
);

  tpe_cmd_t    cmd;
  tpe_status_t status;

  tpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tpe_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .sample_i          (sample_i),
    .capture_end_i     (capture_end_i),
    .raw_value_o       (raw_value_o),
    .smoothed_value_o  (smoothed_value_o),
    .pulse_done_o      (pulse_done_o),
    .pulse_abandoned_o (pulse_abandoned_o),
    .pulse_peak_o      (pulse_peak_o),
    .pulse_area_o      (pulse_area_o)
  );

  // A result never both completes and abandons a pulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pulse_done_o && pulse_abandoned_o))
    else $error("result flags pulse as both done and abandoned");

  // Peak and area are zero on every result that does not close a pulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pulse_done_o) |-> (pulse_peak_o == '0 && pulse_area_o == '0))
    else $error("peak or area set on a result that does not close a pulse");

  // The block is busy in the cycle after it takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted request");

endmodule
